// ===== sv/distance_median_slew_ema_filter_defines.svh =====
// ----------------------------------------------------------------------------
// distance filter assertion macros
// concurrent check helpers clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef DISTANCE_MEDIAN_SLEW_EMA_FILTER_DEFINES_SVH
`define DISTANCE_MEDIAN_SLEW_EMA_FILTER_DEFINES_SVH

// consequent must hold in the same cycle
`define DMF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// consequent must hold in the following cycle
`define DMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== sv/dmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmf_pkg
// shared types, constants and codes of the distance median/slew/ema filter
// ----------------------------------------------------------------------------
package dmf_pkg;

	// geometry
	localparam int CHANNELS  = 4;
	localparam int WINDOW    = 5;
	localparam int QDEPTH    = 2;

	// field widths
	localparam int DIST_W    = 16;
	localparam int CH_W      = 2;
	localparam int SPIKE_W   = 8;
	localparam int ALPHA_W   = 9;
	localparam int CFG_IDX_W = 3;

	// derived widths
	localparam int CHI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WIN_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W    = $clog2(WINDOW + 1);
	localparam int RING_AW   = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int PROD_W    = DIST_W + ALPHA_W;

	localparam logic [SPIKE_W-1:0] SPIKE_MAX = '1;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAR_LEVEL,
		REG_WARNING_LEVEL,
		REG_SPIKE_CONFIRM,
		REG_MIN_VALID,
		REG_MAX_VALID,
		REG_MAX_STEP,
		REG_ALPHA_Q8
	} cfg_reg_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BELOW_MIN = 2'd1,
		ST_FAULT     = 2'd2,
		ST_UPSTREAM  = 2'd3
	} status_t;

	// request class decided by the front
	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_PASS,
		KIND_CLEAR
	} kind_t;

	// back sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EVAL,
		BK_READ,
		BK_SLEW,
		BK_MULT,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [DIST_W-1:0]  far_level;
		logic [DIST_W-1:0]  warning_level;
		logic [SPIKE_W-1:0] spike_confirm;
		logic [DIST_W-1:0]  min_valid;
		logic [DIST_W-1:0]  max_valid;
		logic [DIST_W-1:0]  max_step;
		logic [ALPHA_W-1:0] alpha_q8;
	} cfg_t;

	// one classified request in the queue
	typedef struct packed {
		kind_t             kind;
		status_t           pass_status;
		logic [CH_W-1:0]   channel;
		logic [DIST_W-1:0] raw_distance;
		logic              detected_in;
	} item_t;

	// queue status toward front and top
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef logic [WINDOW-1:0][DIST_W-1:0] win_vec_t;

endpackage

// ===== sv/dmf_ifs.sv =====
// ----------------------------------------------------------------------------
// dmf interfaces
// sample request, result and configuration write channels
// ----------------------------------------------------------------------------
interface dmf_in_if;
	import dmf_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [CH_W-1:0]   channel;
	logic [DIST_W-1:0] raw_distance;
	logic              upstream_ok;
	logic              detected_in;

	modport source (output valid, func, channel, raw_distance, upstream_ok, detected_in,
		input ready);
	modport sink (input valid, func, channel, raw_distance, upstream_ok, detected_in,
		output ready);
endinterface

interface dmf_out_if;
	import dmf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] filtered_distance;
	logic              object_detected;
	logic [1:0]        status;

	modport source (output valid, filtered_distance, object_detected, status, input ready);
	modport sink (input valid, filtered_distance, object_detected, status, output ready);
endinterface

interface dmf_cfg_if;
	import dmf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIST_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dmf_front.sv =====
// ----------------------------------------------------------------------------
// dmf_front
// accepts sample requests and classifies them for the queue
// ----------------------------------------------------------------------------
module dmf_front (
	dmf_in_if.sink           samples,
	input  dmf_pkg::q_stat_t stat,
	output logic             push,
	output dmf_pkg::item_t   item
);
	import dmf_pkg::*;

	// accept whenever the queue has room
	assign samples.ready = !stat.full;
	assign push          = samples.valid && !stat.full;

	// classify: clear, pass through, or sample for the back
	always_comb begin
		item.channel      = samples.channel;
		item.raw_distance = samples.raw_distance;
		item.detected_in  = samples.detected_in;
		item.pass_status  = ST_OK;
		if (samples.func) begin
			item.kind = KIND_CLEAR;
		end else if (!samples.upstream_ok) begin
			item.kind        = KIND_PASS;
			item.pass_status = ST_UPSTREAM;
		end else if (32'(samples.channel) >= CHANNELS) begin
			item.kind = KIND_PASS;
		end else begin
			item.kind = KIND_SAMPLE;
		end
	end
endmodule

// ===== sv/dmf_queue.sv =====
// ----------------------------------------------------------------------------
// dmf_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module dmf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dmf_pkg::item_t   push_item,
	input  logic             pop,
	output dmf_pkg::item_t   head,
	output logic             head_valid,
	output dmf_pkg::q_stat_t stat
);
	import dmf_pkg::*;

	item_t             slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (32'(count_q) == QDEPTH);
	assign stat.empty = (count_q == '0);
	assign head_valid = !stat.empty;
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

// ===== sv/dmf_back.sv =====
// ----------------------------------------------------------------------------
// dmf_back
// per-channel screening, sample ring, median, slew limit and ema
// ----------------------------------------------------------------------------
module dmf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  dmf_pkg::cfg_t  cfg,
	input  dmf_pkg::item_t head,
	input  logic           head_valid,
	output logic           pop,
	dmf_out_if.source      results
);
	import dmf_pkg::*;

	// sorted insertion of one value into the valid prefix of cnt entries
	function automatic win_vec_t insert_sorted(win_vec_t arr, logic [FILL_W-1:0] cnt,
		logic [DIST_W-1:0] v);
		win_vec_t res;
		logic     keep;
		logic     prev_keep;
		for (int j = 0; j < WINDOW; j++) begin
			keep = (FILL_W'(j) < cnt) && (arr[j] <= v);
			if (j == 0) begin
				prev_keep = 1'b1;
			end else begin
				prev_keep = (FILL_W'(j - 1) < cnt) && (arr[j-1] <= v);
			end
			if (keep) begin
				res[j] = arr[j];
			end else if (prev_keep) begin
				res[j] = v;
			end else begin
				res[j] = arr[j-1];
			end
		end
		return res;
	endfunction

	back_state_t          state_q;
	back_state_t          state_d;
	item_t                item_q;

	// per-channel bank state
	logic [DIST_W-1:0]    last_q  [CHANNELS];
	logic [CHANNELS-1:0]  have_q;
	logic [SPIKE_W-1:0]   spike_q [CHANNELS];
	logic [FILL_W-1:0]    fill_q  [CHANNELS];
	logic [WIN_IDX_W-1:0] slot_q  [CHANNELS];

	// sample ring memory
	logic [DIST_W-1:0]    ring_mem [CHANNELS * WINDOW];
	logic [DIST_W-1:0]    rd_data_q;
	logic [RING_AW-1:0]   wr_addr;
	logic [RING_AW-1:0]   rd_addr;

	// median datapath
	logic [FILL_W-1:0]    n_q;
	logic [FILL_W-1:0]    rd_idx_q;
	logic [FILL_W-1:0]    ins_cnt_q;
	logic                 rd_pend_q;
	win_vec_t             sorted_q;
	logic [DIST_W-1:0]    cand_q;

	// pending result and output register
	logic [DIST_W-1:0]    res_dist_q;
	logic                 res_det_q;
	status_t              res_st_q;
	logic                 out_valid_q;
	logic [DIST_W-1:0]    out_dist_q;
	logic                 out_det_q;
	status_t              out_st_q;

	logic [CHI_W-1:0]     ch;
	logic [DIST_W-1:0]    cur_last;
	logic                 cur_have;
	logic [SPIKE_W-1:0]   cur_spike;
	logic [FILL_W-1:0]    cur_fill;
	logic [WIN_IDX_W-1:0] cur_slot;

	logic                 near;
	logic [SPIKE_W-1:0]   spike_inc;
	logic [SPIKE_W-1:0]   spike_nxt;
	logic [WIN_IDX_W-1:0] slot_eff;
	logic [WIN_IDX_W-1:0] slot_nxt;
	logic [FILL_W-1:0]    fill_nxt;
	logic                 ev_store;
	logic [DIST_W-1:0]    ev_dist;
	logic                 ev_det;
	status_t              ev_st;

	logic [DIST_W-1:0]    med;
	logic [DIST_W:0]      up_sum;
	logic [DIST_W-1:0]    slew_cand;
	logic [ALPHA_W-1:0]   alpha_sat;
	logic [PROD_W-1:0]    blend;
	logic [DIST_W-1:0]    ema;

	logic                 rd_issue;
	logic                 push_res;
	logic                 ring_we;
	logic                 ins_last;

	assign ch        = CHI_W'(item_q.channel);
	assign cur_last  = last_q[ch];
	assign cur_have  = have_q[ch];
	assign cur_spike = spike_q[ch];
	assign cur_fill  = fill_q[ch];
	assign cur_slot  = slot_q[ch];

	// near spike screening, range screening and ring bookkeeping
	always_comb begin
		near      = cur_have && (cur_last > cfg.far_level)
			&& (item_q.raw_distance < cfg.warning_level);
		spike_inc = (cur_spike == SPIKE_MAX) ? cur_spike : cur_spike + 1'b1;
		spike_nxt = near ? spike_inc : '0;
		slot_eff  = (32'(cur_slot) >= WINDOW) ? '0 : cur_slot;
		slot_nxt  = (32'(slot_eff) == WINDOW - 1) ? '0 : slot_eff + 1'b1;
		fill_nxt  = (32'(cur_fill) < WINDOW) ? cur_fill + 1'b1 : cur_fill;
		ev_store  = 1'b0;
		ev_dist   = item_q.raw_distance;
		ev_det    = item_q.detected_in;
		ev_st     = item_q.pass_status;
		if (item_q.kind == KIND_SAMPLE) begin
			if (near && (spike_inc < cfg.spike_confirm)) begin
				ev_dist = cur_last;
				ev_det  = 1'b1;
				ev_st   = ST_OK;
			end else if (item_q.raw_distance < cfg.min_valid) begin
				ev_dist = cfg.min_valid;
				ev_det  = 1'b1;
				ev_st   = ST_BELOW_MIN;
			end else if (item_q.raw_distance > cfg.max_valid) begin
				ev_dist = cur_have ? cur_last : '0;
				ev_det  = cur_have;
				ev_st   = cur_have ? ST_OK : ST_FAULT;
			end else begin
				ev_store = 1'b1;
			end
		end
	end

	// upper median, slew limit and ema blend
	always_comb begin
		med       = sorted_q[WIN_IDX_W'(n_q >> 1)];
		up_sum    = {1'b0, cur_last} + {1'b0, cfg.max_step};
		slew_cand = med;
		if (cur_have) begin
			if ((med > cur_last) && ((med - cur_last) > cfg.max_step)) begin
				slew_cand = up_sum[DIST_W] ? DIST_MAX : up_sum[DIST_W-1:0];
			end else if ((med < cur_last) && ((cur_last - med) > cfg.max_step)) begin
				slew_cand = cur_last - cfg.max_step;
			end
		end
		alpha_sat = cfg.alpha_q8[ALPHA_W-1] ? ALPHA_ONE : cfg.alpha_q8;
		blend     = PROD_W'(alpha_sat) * PROD_W'(cand_q)
			+ PROD_W'(ALPHA_ONE - alpha_sat) * PROD_W'(cur_last);
		ema       = cur_have ? blend[DIST_W+7:8] : cand_q;
	end

	// ring addresses
	assign wr_addr = RING_AW'(ch) * RING_AW'(WINDOW) + RING_AW'(slot_eff);
	assign rd_addr = RING_AW'(ch) * RING_AW'(WINDOW) + RING_AW'(rd_idx_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				if (item_q.kind == KIND_CLEAR) begin
					state_d = BK_IDLE;
				end else if (ev_store) begin
					state_d = BK_READ;
				end else begin
					state_d = BK_DONE;
				end
			end
			BK_READ: begin
				if (ins_last) begin
					state_d = BK_SLEW;
				end
			end
			BK_SLEW: state_d = BK_MULT;
			BK_MULT: state_d = BK_DONE;
			BK_DONE: begin
				if (push_res) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && head_valid;
		rd_issue = (state_q == BK_READ) && (rd_idx_q < n_q);
		ins_last = (state_q == BK_READ) && rd_pend_q && (ins_cnt_q + 1'b1 == n_q);
		push_res = (state_q == BK_DONE) && (!out_valid_q || results.ready);
		ring_we  = (state_q == BK_EVAL) && ev_store;
	end

	// state register, bank state and read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			have_q      <= '0;
			rd_idx_q    <= '0;
			ins_cnt_q   <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				last_q[c]  <= '0;
				spike_q[c] <= '0;
				fill_q[c]  <= '0;
				slot_q[c]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == BK_EVAL) begin
				if (item_q.kind == KIND_CLEAR) begin
					have_q <= '0;
					for (int c = 0; c < CHANNELS; c++) begin
						last_q[c]  <= '0;
						spike_q[c] <= '0;
						fill_q[c]  <= '0;
						slot_q[c]  <= '0;
					end
				end else if (item_q.kind == KIND_SAMPLE) begin
					spike_q[ch] <= spike_nxt;
					if (ev_store) begin
						slot_q[ch] <= slot_nxt;
						fill_q[ch] <= fill_nxt;
					end
				end
				rd_idx_q  <= '0;
				ins_cnt_q <= '0;
				rd_pend_q <= 1'b0;
			end
			if (state_q == BK_READ) begin
				rd_pend_q <= rd_issue;
				if (rd_issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (rd_pend_q) begin
					ins_cnt_q <= ins_cnt_q + 1'b1;
				end
			end
			if (state_q == BK_MULT) begin
				last_q[ch] <= ema;
				have_q[ch] <= 1'b1;
			end
			if (push_res) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == BK_EVAL) begin
			n_q        <= fill_nxt;
			res_dist_q <= ev_dist;
			res_det_q  <= ev_det;
			res_st_q   <= ev_st;
		end
		if ((state_q == BK_READ) && rd_pend_q) begin
			sorted_q <= insert_sorted(sorted_q, ins_cnt_q, rd_data_q);
		end
		if (state_q == BK_SLEW) begin
			cand_q <= slew_cand;
		end
		if (state_q == BK_MULT) begin
			res_dist_q <= ema;
			res_det_q  <= 1'b1;
			res_st_q   <= ST_OK;
		end
		if (push_res) begin
			out_dist_q <= res_dist_q;
			out_det_q  <= res_det_q;
			out_st_q   <= res_st_q;
		end
	end

	// ring memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wr_addr] <= item_q.raw_distance;
		end
		if (rd_issue) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	assign results.valid             = out_valid_q;
	assign results.filtered_distance = out_dist_q;
	assign results.object_detected   = out_det_q;
	assign results.status            = out_st_q;
endmodule

// ===== sv/distance_median_slew_ema_filter.sv =====
// ----------------------------------------------------------------------------
// distance_median_slew_ema_filter
// per-channel ranging filter: spike hold, range screen, median, slew, ema
// ----------------------------------------------------------------------------
// usage
//   samples : valid/ready request channel, one raw distance per request with
//             its channel, upstream status and detected flag; func set clears
//             all channel banks and produces no result
//   results : valid/ready channel, one result per process request
//   cfg     : valid/ready write channel, index selects the register; always
//             ready, write only while no request is in flight
// sequencing
//   requests are classified and queued (two entries), then run one at a time
//   in the back sequencer; a stored sample reads the channel's n ring entries,
//   n being its fill count (1..5), through the one-read-per-cycle ring port
//   into the insertion sorter, then passes the slew and ema steps; held,
//   screened and passed requests go straight to the result, a clear yields none
// reset
//   arst_n clears all banks and loads the register defaults; ring contents
//   stay undefined and are never read before written
// stall
//   a result waits in the output register; the back holds its next result
//   and the queue keeps taking requests until full, then samples.ready drops
// ----------------------------------------------------------------------------
`include "distance_median_slew_ema_filter_defines.svh"

module distance_median_slew_ema_filter (
	input logic     clk,
	input logic     arst_n,
	dmf_in_if.sink  samples,
	dmf_out_if.source results,
	dmf_cfg_if.sink cfg
);
	import dmf_pkg::*;

	cfg_t    cfg_q;
	item_t   push_item;
	item_t   head;
	logic    push;
	logic    pop;
	logic    head_valid;
	q_stat_t q_stat;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.far_level     <= DIST_W'(2240);
			cfg_q.warning_level <= DIST_W'(800);
			cfg_q.spike_confirm <= SPIKE_W'(3);
			cfg_q.min_valid     <= DIST_W'(32);
			cfg_q.max_valid     <= DIST_W'(6400);
			cfg_q.max_step      <= DIST_W'(800);
			cfg_q.alpha_q8      <= ALPHA_W'(77);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_FAR_LEVEL:     cfg_q.far_level     <= cfg.data;
				REG_WARNING_LEVEL: cfg_q.warning_level <= cfg.data;
				REG_SPIKE_CONFIRM: cfg_q.spike_confirm <= cfg.data[SPIKE_W-1:0];
				REG_MIN_VALID:     cfg_q.min_valid     <= cfg.data;
				REG_MAX_VALID:     cfg_q.max_valid     <= cfg.data;
				REG_MAX_STEP:      cfg_q.max_step      <= cfg.data;
				REG_ALPHA_Q8:      cfg_q.alpha_q8      <= cfg.data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// front: accept and classify
	dmf_front u_front (
		.samples (samples),
		.stat    (q_stat),
		.push    (push),
		.item    (push_item)
	);

	// decoupling queue
	dmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.stat       (q_stat)
	);

	// back: per-channel filtering
	dmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.results    (results)
	);

	// checks
	`DMF_ASSERT_SAME(a_full_stalls_front, q_stat.full, !samples.ready)
	`DMF_ASSERT_SAME(a_fault_result_zero, results.valid && (results.status == ST_FAULT), (results.filtered_distance == '0) && !results.object_detected)
	`DMF_ASSERT_SAME(a_below_min_detected, results.valid && (results.status == ST_BELOW_MIN), results.object_detected)
	`DMF_ASSERT_NEXT(a_alpha_write, cfg.valid && cfg.ready && (cfg.index == REG_ALPHA_Q8), cfg_q.alpha_q8 == $past(cfg.data[ALPHA_W-1:0]))
endmodule
